@@ src/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with active-low reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle: when the antecedent holds, so must the consequent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/crc8cf_pkg.sv @@
// ============================================================================
// CRC-8 command frame package
// Command codes, operation classes, queue entry type and the CRC-8 function.
// ============================================================================
`default_nettype none

package crc8cf_pkg;

    // Command byte codes.
    localparam logic [7:0] CMD_GET_USER    = 8'h01;
    localparam logic [7:0] CMD_GET_VERSION = 8'h02;
    localparam logic [7:0] CMD_GET_STATUS  = 8'h03;
    localparam logic [7:0] CMD_GET_CRC     = 8'h04;
    localparam logic [7:0] CMD_GET_FLOW    = 8'h05;
    localparam logic [7:0] CMD_SET_USER    = 8'h11;
    localparam logic [7:0] CMD_CLR_STATUS  = 8'h13;
    localparam logic [7:0] CMD_SET_CRC     = 8'h14;
    localparam logic [7:0] CMD_SET_FLOW    = 8'h15;

    // Status bit positions and width.
    localparam int STS_W       = 3;
    localparam int STS_INVALID = 0;
    localparam int STS_CRC_ERR = 1;

    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] ALL_ZEROS = 32'h0000_0000;
    localparam logic [7:0]  CRC_POLY  = 8'h07;

    // Frame length in bits covered by the CRC: command byte and four data bytes.
    localparam int MSG_W = 40;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation class decided by the front end.
    typedef enum logic [3:0] {
        OP_GET_USER,
        OP_GET_VERSION,
        OP_GET_STATUS,
        OP_GET_CRC,
        OP_GET_FLOW,
        OP_SET_USER,
        OP_CLR_STATUS,
        OP_SET_CRC,
        OP_SET_FLOW,
        OP_INVALID,
        OP_CRC_ERR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  cmd;
        logic [31:0] data;
    } q_entry_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // The CRC is linear, so each message bit contributes a fixed column.
    typedef logic [7:0] crc_col_t [MSG_W];

    function automatic crc_col_t crc_columns();
        crc_col_t   cols;
        logic [7:0] c;
        for (int k = 0; k < MSG_W; k++)
        begin
            c = 8'h80;
            for (int s = 0; s <= k; s++)
            begin
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            cols[k] = c;
        end
        return cols;
    endfunction

    localparam crc_col_t CRC_COLS = crc_columns();

    // CRC-8 over the command byte and then data bytes, least significant first.
    function automatic logic [7:0] crc8_frame(input logic [7:0] cmd, input logic [31:0] data);
        logic [MSG_W-1:0] msg;
        logic [7:0]       c;
        msg = {cmd, data[7:0], data[15:8], data[23:16], data[31:24]};
        c   = 8'h00;
        for (int k = 0; k < MSG_W; k++)
        begin
            if (msg[k])
            begin
                c = c ^ CRC_COLS[k];
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/crc8_command_frame_register_access_core.sv @@
// ============================================================================
// CRC-8 command frame register access core
// Checks CRC-8 protected command frames and serves register get/set commands.
// ============================================================================
// Each frame is accepted while the queue has room, and its reply passes through
// the queue and the output register; one frame per cycle is sustained while the
// output side is ready. The front end checks the CRC-8 and decodes the command
// in the accepting cycle, a two-entry queue holds it, and the back end performs
// the register access and computes the reply CRC-8 into the output register.
// A stalled output fills the queue first, then input ready drops.
`default_nettype none
`include "assert_macros.svh"

module crc8_command_frame_register_access_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,      // version_word[31:0]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // frame_data[31:0], frame_crc[39:32]
    input  wire logic [7:0]  s_axis_tuser,   // cmd[7:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // reply_data[31:0], reply_crc[39:32]
    output logic [7:0]       m_axis_tuser    // reply_cmd[7:0]
);

    crc8cf_pkg::q_status_t q_stat;
    crc8cf_pkg::q_entry_t  q_wdata;
    crc8cf_pkg::q_entry_t  q_rdata;
    logic                  q_push;
    logic                  q_pop;

    crc8cf_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    crc8cf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    crc8cf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_stat        (q_stat),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A stalled reply must not be overwritten by a new command.
    `ASSERT_SAME(a_no_pop_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, !q_pop, "queue popped while reply stalled")
    // An accepted frame is held in the queue afterwards.
    `ASSERT_NEXT(a_push_lands, clk, rst_n, s_axis_tvalid && s_axis_tready, q_stat.not_empty, "accepted frame missing from queue")
    // Every command taken from the queue produces a reply.
    `ASSERT_NEXT(a_pop_replies, clk, rst_n, q_pop, m_axis_tvalid, "executed command produced no reply")

endmodule

`default_nettype wire

@@ src/crc8cf_front.sv @@
// ============================================================================
// CRC-8 command frame front end
// Checks the frame CRC, classifies the command and pushes it to the queue.
// ============================================================================
`default_nettype none

module crc8cf_front (
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [39:0]           s_axis_tdata,  // frame_data[31:0], frame_crc[39:32]
    input  wire logic [7:0]            s_axis_tuser,  // cmd[7:0]
    input  wire crc8cf_pkg::q_status_t q_stat,
    output logic                       q_push,
    output crc8cf_pkg::q_entry_t       q_wdata
);

    logic [31:0]     frame_data;
    logic [7:0]      frame_crc;
    logic            crc_ok;
    crc8cf_pkg::op_t cmd_op;

    assign frame_data = s_axis_tdata[31:0];
    assign frame_crc  = s_axis_tdata[39:32];

    // Accept a transfer whenever the queue has room.
    assign s_axis_tready = !q_stat.full;
    assign q_push        = s_axis_tvalid && !q_stat.full;

    assign crc_ok = (crc8cf_pkg::crc8_frame(s_axis_tuser, frame_data) == frame_crc);

    // Command decoder.
    always_comb
    begin
        unique case (s_axis_tuser)
            crc8cf_pkg::CMD_GET_USER:    cmd_op = crc8cf_pkg::OP_GET_USER;
            crc8cf_pkg::CMD_GET_VERSION: cmd_op = crc8cf_pkg::OP_GET_VERSION;
            crc8cf_pkg::CMD_GET_STATUS:  cmd_op = crc8cf_pkg::OP_GET_STATUS;
            crc8cf_pkg::CMD_GET_CRC:     cmd_op = crc8cf_pkg::OP_GET_CRC;
            crc8cf_pkg::CMD_GET_FLOW:    cmd_op = crc8cf_pkg::OP_GET_FLOW;
            crc8cf_pkg::CMD_SET_USER:    cmd_op = crc8cf_pkg::OP_SET_USER;
            crc8cf_pkg::CMD_CLR_STATUS:  cmd_op = crc8cf_pkg::OP_CLR_STATUS;
            crc8cf_pkg::CMD_SET_CRC:     cmd_op = crc8cf_pkg::OP_SET_CRC;
            crc8cf_pkg::CMD_SET_FLOW:    cmd_op = crc8cf_pkg::OP_SET_FLOW;
            default:                     cmd_op = crc8cf_pkg::OP_INVALID;
        endcase
    end

    // A CRC mismatch overrides the command class.
    always_comb
    begin
        q_wdata.op   = crc_ok ? cmd_op : crc8cf_pkg::OP_CRC_ERR;
        q_wdata.cmd  = s_axis_tuser;
        q_wdata.data = frame_data;
    end

endmodule

`default_nettype wire

@@ src/crc8cf_queue.sv @@
// ============================================================================
// CRC-8 command frame queue
// Short first-in first-out buffer between the front end and the back end.
// ============================================================================
`default_nettype none

module crc8cf_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire crc8cf_pkg::q_entry_t  wdata,
    input  wire logic                  pop,
    output crc8cf_pkg::q_entry_t       rdata,
    output crc8cf_pkg::q_status_t      stat
);

    crc8cf_pkg::q_entry_t               mem_reg [crc8cf_pkg::QUEUE_DEPTH];
    logic [crc8cf_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [crc8cf_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [crc8cf_pkg::QCNT_W-1:0]      count_reg, count_next;

    localparam logic [crc8cf_pkg::QPTR_W-1:0] PTR_LAST =
        crc8cf_pkg::QPTR_W'(crc8cf_pkg::QUEUE_DEPTH - 1);
    localparam logic [crc8cf_pkg::QCNT_W-1:0] CNT_FULL =
        crc8cf_pkg::QCNT_W'(crc8cf_pkg::QUEUE_DEPTH);

    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == CNT_FULL);
    assign rdata          = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ src/crc8cf_back.sv @@
// ============================================================================
// CRC-8 command frame back end
// Executes queued commands on the register set and builds the reply.
// ============================================================================
`default_nettype none

module crc8cf_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [31:0]           cfg_wdata,
    input  wire crc8cf_pkg::q_status_t q_stat,
    input  wire crc8cf_pkg::q_entry_t  q_rdata,
    output logic                       q_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [39:0]                m_axis_tdata,  // reply_data[31:0], reply_crc[39:32]
    output logic [7:0]                 m_axis_tuser   // reply_cmd[7:0]
);

    logic [31:0]                   version_reg;
    logic [31:0]                   user_reg, user_next;
    logic [crc8cf_pkg::STS_W-1:0]  status_reg, status_next;
    logic [31:0]                   crcw_reg, crcw_next;
    logic [31:0]                   flow_reg, flow_next;
    logic                          out_valid_reg;
    logic [7:0]                    out_cmd_reg;
    logic [31:0]                   out_data_reg;
    logic [7:0]                    out_crc_reg;
    logic [31:0]                   reply;

    // Take the head of the queue when the output register is free or draining.
    assign q_pop = q_stat.not_empty && (!out_valid_reg || m_axis_tready);

    // Register access for the command at the head of the queue.
    always_comb
    begin
        user_next   = user_reg;
        status_next = status_reg;
        crcw_next   = crcw_reg;
        flow_next   = flow_reg;
        reply       = crc8cf_pkg::ALL_ZEROS;
        unique case (q_rdata.op)
            crc8cf_pkg::OP_GET_USER:    reply = user_reg;
            crc8cf_pkg::OP_GET_VERSION: reply = version_reg;
            crc8cf_pkg::OP_GET_STATUS:  reply = {{(32 - crc8cf_pkg::STS_W){1'b0}}, status_reg};
            crc8cf_pkg::OP_GET_CRC:     reply = crcw_reg;
            crc8cf_pkg::OP_GET_FLOW:    reply = flow_reg;
            crc8cf_pkg::OP_SET_USER:    user_next = q_rdata.data;
            crc8cf_pkg::OP_CLR_STATUS:
            begin
                status_next = status_reg & ~q_rdata.data[crc8cf_pkg::STS_W-1:0];
            end
            crc8cf_pkg::OP_SET_CRC:     crcw_next = q_rdata.data;
            crc8cf_pkg::OP_SET_FLOW:    flow_next = q_rdata.data;
            crc8cf_pkg::OP_INVALID:
            begin
                status_next[crc8cf_pkg::STS_INVALID] = 1'b1;
                reply = crc8cf_pkg::ALL_ONES;
            end
            crc8cf_pkg::OP_CRC_ERR:
            begin
                status_next[crc8cf_pkg::STS_CRC_ERR] = 1'b1;
                reply = crc8cf_pkg::ALL_ONES;
            end
            default:
            begin
                reply = crc8cf_pkg::ALL_ONES;
            end
        endcase
    end

    // State registers; user, status, CRC and flow update only when a command is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg   <= '0;
            user_reg      <= '0;
            status_reg    <= '0;
            crcw_reg      <= '0;
            flow_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                version_reg <= cfg_wdata;
            end
            if (q_pop)
            begin
                user_reg   <= user_next;
                status_reg <= status_next;
                crcw_reg   <= crcw_next;
                flow_reg   <= flow_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Reply payload register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_cmd_reg  <= q_rdata.cmd;
            out_data_reg <= reply;
            out_crc_reg  <= crc8cf_pkg::crc8_frame(q_rdata.cmd, reply);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_crc_reg, out_data_reg};
    assign m_axis_tuser  = out_cmd_reg;

endmodule

`default_nettype wire
